// ----- hw/rtl/lag_pkg.sv -----
package lag_pkg;

  localparam int GRID_MAX_DEF    = 64;  // default side length of the cell store
  localparam int GRID_RESET_SIZE = 64;  // active width and height after reset
  localparam int CFG_W           = 7;   // width of a size register
  localparam int CFG_IDX_W       = 1;   // width of a register index
  localparam int OP_W            = 2;
  localparam int COORD_W         = 6;
  localparam int NB_W            = 4;   // holds a neighbour count of 0..8

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [NB_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NB_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_ADV,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  // What the datapath does with the row read in the previous cycle
  typedef enum logic [2:0] {
    K_CELL_WR,
    K_CELL_RD,
    K_ADV,
    K_SWEEP,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    logic  capture;  // latch the input fields
    logic  rd;       // read a row this cycle
    kind_t kind;
    logic  last;     // last row of the transaction: emit the result
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] height;
  } status_t;

endpackage

// ----- hw/rtl/lag_datapath.sv -----
module lag_datapath #(
  parameter int GRID_MAX = lag_pkg::GRID_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lag_pkg::cmd_t                   cmd,
  input  logic [$clog2(GRID_MAX+1)-1:0]   cmd_row,
  input  logic [lag_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [lag_pkg::COORD_W-1:0]     in_cell_y,
  input  logic                            in_cell_value,
  input  logic                            cfg_we,
  input  logic [lag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lag_pkg::CFG_W-1:0]       cfg_data,
  output lag_pkg::status_t                sts,
  output logic                            out_valid,
  output logic                            out_cell_state
);
  import lag_pkg::*;

  localparam int ROW_W = $clog2(GRID_MAX);
  localparam int CNT_W = $clog2(GRID_MAX+1);
  localparam int RESET_SIZE = (GRID_RESET_SIZE > GRID_MAX) ? GRID_MAX : GRID_RESET_SIZE;

  logic [CFG_W-1:0]    width_r, height_r, cfg_clamped;
  logic [COORD_W-1:0]  x_r, y_r;
  logic                v_r, in_area_r;

  logic [GRID_MAX-1:0] cell_mem_r [GRID_MAX];
  logic [GRID_MAX-1:0] row_vld_r;
  logic [GRID_MAX-1:0] mem_q_r;
  logic                vld_q_r;

  logic                b_vld_r, b_last_r;
  kind_t               b_kind_r;
  logic [CNT_W-1:0]    b_row_r;

  logic [GRID_MAX-1:0] w_up_r, w_mid_r;
  logic                out_valid_r, out_state_r;

  logic [ROW_W-1:0]    rd_addr, wr_addr, xi;
  logic                rd_ok, wr_en, clr_all;
  logic [GRID_MAX-1:0] cur, wmask, next_row, wr_data;

  // Size registers, clamped to the store size
  always_comb cfg_clamped = (int'(cfg_data) > GRID_MAX) ? CFG_W'(GRID_MAX) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(RESET_SIZE);
      height_r <= CFG_W'(RESET_SIZE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_clamped;
        REG_HEIGHT: height_r <= cfg_clamped;
      endcase
    end
  end

  assign sts.height = height_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r       <= in_cell_x;
      y_r       <= in_cell_y;
      v_r       <= in_cell_value;
      in_area_r <= (CFG_W'(in_cell_x) < width_r) && (CFG_W'(in_cell_y) < height_r);
    end
  end

  // Row read: address and range check
  always_comb begin
    rd_addr = ROW_W'(cmd_row);
    unique case (cmd.kind)
      K_CELL_WR, K_CELL_RD: begin
        rd_addr = ROW_W'(y_r);
        rd_ok   = in_area_r;
      end
      K_ADV:   rd_ok = int'(cmd_row) < int'(height_r);
      default: rd_ok = int'(cmd_row) < GRID_MAX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      vld_q_r <= rd_ok && row_vld_r[rd_addr];
      if (rd_ok) begin
        mem_q_r <= cell_mem_r[rd_addr];
      end
      b_kind_r <= cmd.kind;
      b_last_r <= cmd.last;
      b_row_r  <= cmd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= cmd.rd;
    end
  end

  // A row never written since the last clear reads as dead
  assign cur = vld_q_r ? mem_q_r : '0;
  assign xi  = ROW_W'(x_r);

  always_comb begin
    for (int c = 0; c < GRID_MAX; c++) begin
      wmask[c] = c < int'(width_r);
    end
  end

  // One generation of a row from the rows above, at and below it
  always_comb begin
    logic [GRID_MAX+1:0] up_p, mid_p, dn_p;
    logic [NB_W-1:0]     nb;
    up_p  = {1'b0, w_up_r, 1'b0};
    mid_p = {1'b0, w_mid_r, 1'b0};
    dn_p  = {1'b0, cur, 1'b0};
    for (int c = 0; c < GRID_MAX; c++) begin
      nb = NB_W'(up_p[c]) + NB_W'(up_p[c+1]) + NB_W'(up_p[c+2])
         + NB_W'(mid_p[c]) + NB_W'(mid_p[c+2])
         + NB_W'(dn_p[c]) + NB_W'(dn_p[c+1]) + NB_W'(dn_p[c+2]);
      next_row[c] = wmask[c] &&
                    ((nb == BIRTH_COUNT) || (mid_p[c+1] && (nb == SURVIVE_COUNT)));
    end
  end

  // Write-back of the row in hand
  always_comb begin
    wr_en   = 1'b0;
    clr_all = 1'b0;
    wr_addr = ROW_W'(b_row_r);
    wr_data = cur;
    if (b_vld_r) begin
      unique case (b_kind_r)
        K_CELL_WR: begin
          wr_en       = in_area_r;
          wr_addr     = ROW_W'(y_r);
          wr_data[xi] = v_r;
        end
        K_ADV: begin
          wr_en   = b_row_r != '0;
          wr_addr = ROW_W'(b_row_r - CNT_W'(1));
          wr_data = next_row;
        end
        K_SWEEP: begin
          wr_en   = 1'b1;
          wr_data = (int'(b_row_r) < int'(height_r)) ? (cur & wmask) : '0;
        end
        K_CLEAR: clr_all = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (clr_all) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Window of the two rows above the one just read
  always_ff @(posedge clk) begin
    if (b_vld_r && (b_kind_r == K_ADV)) begin
      w_up_r  <= (b_row_r == '0) ? '0 : w_mid_r;
      w_mid_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_vld_r && b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    out_state_r <= b_vld_r && b_last_r && (b_kind_r == K_CELL_RD) && in_area_r && cur[xi];
  end

  assign out_valid      = out_valid_r;
  assign out_cell_state = out_state_r;

endmodule

// ----- hw/rtl/lag_ctrl.sv -----
module lag_ctrl #(
  parameter int GRID_MAX = lag_pkg::GRID_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lag_pkg::OP_W-1:0]      in_op,
  input  logic                          cfg_we,
  input  lag_pkg::status_t              sts,
  output logic                          busy,
  output lag_pkg::cmd_t                 cmd,
  output logic [$clog2(GRID_MAX+1)-1:0] cmd_row
);
  import lag_pkg::*;

  localparam int CNT_W = $clog2(GRID_MAX+1);

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             adv_end, sweep_end;

  assign adv_end   = int'(cnt_r) == int'(sts.height);
  assign sweep_end = int'(cnt_r) == GRID_MAX - 1;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    if (cfg_we) begin
      state_nxt = ST_SWEEP;
      cnt_nxt   = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_nxt    = op_t'(in_op);
            cnt_nxt   = '0;
            state_nxt = (op_t'(in_op) == OP_ADVANCE) ? ST_ADV : ST_ISSUE;
          end
        end
        ST_ISSUE: state_nxt = ST_DRAIN;
        ST_ADV: begin
          if (adv_end) begin
            state_nxt = ST_DRAIN;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ST_SWEEP: begin
          if (sweep_end) begin
            state_nxt = ST_DRAIN;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ST_DRAIN: state_nxt = ST_IDLE;
        default:  state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.kind    = K_CELL_RD;
    unique case (state_r)
      ST_IDLE: cmd.capture = start;
      ST_ISSUE: begin
        cmd.rd   = 1'b1;
        cmd.last = 1'b1;
        unique case (op_r)
          OP_WRITE:   cmd.kind = K_CELL_WR;
          OP_READ:    cmd.kind = K_CELL_RD;
          OP_ADVANCE: cmd.kind = K_ADV;
          OP_CLEAR:   cmd.kind = K_CLEAR;
        endcase
      end
      ST_ADV: begin
        cmd.rd   = 1'b1;
        cmd.kind = K_ADV;
        cmd.last = adv_end;
      end
      ST_SWEEP: begin
        cmd.rd   = 1'b1;
        cmd.kind = K_SWEEP;
      end
      default: ;
    endcase
  end

  assign cmd_row = cnt_r;
  assign busy    = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_WRITE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/life_automaton_grid.sv -----
// Game of life grid (rule B3/S23) on a GRID_MAX by GRID_MAX store of cells, of which an
// active area of width by height cells is used. A transaction is taken when start is high
// and busy is low; each transaction gives one result, shown on out_cell_state for exactly
// one cycle with out_valid high, and the receiver cannot hold it off. Write, read and
// clear go from idle through an issue state, in which the row is read, and a drain state
// back to idle; the result is registered after the row read. An advance reads the cell
// store one row per cycle through a three-row window, with each new row written back
// while a later row is read. A write of either size register starts a pass over all
// GRID_MAX rows that drops cells outside the new area; busy is high from the cycle after
// the write until the pass ends, so do not start a transaction in the same cycle as a
// register write. Reset needs no clearing pass.
module life_automaton_grid #(
  parameter int GRID_MAX = lag_pkg::GRID_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lag_pkg::OP_W-1:0]      in_op,
  input  logic [lag_pkg::COORD_W-1:0]   in_cell_x,
  input  logic [lag_pkg::COORD_W-1:0]   in_cell_y,
  input  logic                          in_cell_value,
  output logic                          out_valid,
  output logic                          out_cell_state,
  input  logic                          cfg_we,
  input  logic [lag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lag_pkg::CFG_W-1:0]     cfg_data
);
  import lag_pkg::*;

  localparam int CNT_W = $clog2(GRID_MAX+1);

  // Commands from the sequencer, and the active height back for the end of an advance
  cmd_t             cmd;
  status_t          sts;
  logic [CNT_W-1:0] cmd_row;

  // Sequence rows: one per cycle during an advance or a size sweep
  lag_ctrl #(
    .GRID_MAX (GRID_MAX)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_op   (in_op),
    .cfg_we  (cfg_we),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd),
    .cmd_row (cmd_row)
  );

  // Hold the cell store, the size registers and the next-generation logic
  lag_datapath #(
    .GRID_MAX (GRID_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cmd_row        (cmd_row),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_value  (in_cell_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_cell_state (out_cell_state)
  );

endmodule

// ----- dv/life_automaton_grid_checker.sv -----
module life_automaton_grid_checker #(
  parameter int GRID_MAX = lag_pkg::GRID_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [lag_pkg::OP_W-1:0]      in_op,
  input  logic [lag_pkg::COORD_W-1:0]   in_cell_x,
  input  logic [lag_pkg::COORD_W-1:0]   in_cell_y,
  input  logic                          in_cell_value,
  input  logic                          out_valid,
  input  logic                          out_cell_state,
  input  logic                          cfg_we,
  input  logic [lag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lag_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  import lag_pkg::*;

  logic [GRID_MAX-1:0] cells [GRID_MAX];
  int area_w;
  int area_h;
  bit cell_state_due [$];
  bit want;

  function automatic int sat_size(logic [CFG_W-1:0] v);
    return (int'(v) > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  // Neighbours beyond the active area count as dead; no wrap-around.
  function automatic bit live_at(int x, int y);
    if (x < 0 || y < 0 || x >= area_w || y >= area_h) return 1'b0;
    return cells[y][x];
  endfunction

  function automatic void drop_outside();
    for (int y = 0; y < GRID_MAX; y++)
      for (int x = 0; x < GRID_MAX; x++)
        if (x >= area_w || y >= area_h) cells[y][x] = 1'b0;
  endfunction

  function automatic void next_generation();
    logic [GRID_MAX-1:0] nxt [GRID_MAX];
    int n;
    for (int y = 0; y < GRID_MAX; y++) nxt[y] = '0;
    for (int y = 0; y < area_h; y++) begin
      for (int x = 0; x < area_w; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (dx != 0 || dy != 0) n += int'(live_at(x + dx, y + dy));
        if (n == int'(BIRTH_COUNT) || (cells[y][x] && n == int'(SURVIVE_COUNT)))
          nxt[y][x] = 1'b1;
      end
    end
    cells = nxt;
  endfunction

  // Apply one transaction to the grid and return the cell state it reports.
  function automatic bit apply_transaction(op_t op, int x, int y, bit v);
    bit st;
    st = 1'b0;
    case (op)
      OP_WRITE: begin
        if (x < area_w && y < area_h) cells[y][x] = v;
      end
      OP_READ: begin
        st = live_at(x, y);
      end
      OP_ADVANCE: begin
        next_generation();
      end
      default: begin
        for (int r = 0; r < GRID_MAX; r++) cells[r] = '0;
      end
    endcase
    return st;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_MAX; r++) cells[r] = '0;
      area_w = sat_size(CFG_W'(GRID_RESET_SIZE));
      area_h = sat_size(CFG_W'(GRID_RESET_SIZE));
      cell_state_due.delete();
      fail_count = 0;
    end else begin
      // compare before taking a new transaction: a result never belongs to one
      // accepted at the same edge
      if (out_valid) begin
        if (cell_state_due.size() == 0) begin
          $error("unexpected result: cell_state %0b", out_cell_state);
          fail_count++;
        end else begin
          want = cell_state_due.pop_front();
          if (out_cell_state !== want) begin
            $error("cell_state mismatch: expected %0b, actual %0b", want, out_cell_state);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) area_w = sat_size(cfg_data);
        else if (cfg_index == REG_HEIGHT) area_h = sat_size(cfg_data);
        drop_outside();
      end
      if (start && !busy)
        cell_state_due.push_back(apply_transaction(op_t'(in_op), int'(in_cell_x),
                                                   int'(in_cell_y), in_cell_value));
    end
    outstanding = cell_state_due.size();
  end

endmodule

// ----- dv/tb_life_automaton_grid.sv -----
module tb_life_automaton_grid;
  import lag_pkg::*;

  localparam int GRID_MAX     = GRID_MAX_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // longest thing the block can still be doing once the last result is out:
  // a size sweep over every row
  localparam int DRAIN_CYCLES = GRID_MAX + 8;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_op;
  logic [COORD_W-1:0]   in_cell_x;
  logic [COORD_W-1:0]   in_cell_y;
  logic                 in_cell_value;
  logic                 out_valid;
  logic                 out_cell_state;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int outstanding;
  int cycle_count;
  int idle_pct;      // chance in a hundred that the sender idles a cycle
  int area_w;        // active area as the stimulus sees it, for aiming writes
  int area_h;
  int stim_count;    // transactions that do real work

  life_automaton_grid #(
    .GRID_MAX(GRID_MAX)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_cell_state(out_cell_state),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  life_automaton_grid_checker #(
    .GRID_MAX(GRID_MAX)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_cell_state(out_cell_state),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop should the block hang
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offer one transaction, starting at a falling edge. Idle first at random,
  // then hold start until the block takes it. Start is left high on return so
  // that back-to-back transactions keep it up without a glitch.
  task automatic issue(op_t op, int x, int y, bit v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_cell_x     <= x[COORD_W-1:0];
    in_cell_y     <= y[COORD_W-1:0];
    in_cell_value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    // a write outside the area does nothing, so leave it out of the tally
    if (op != OP_WRITE || (x < area_w && y < area_h)) stim_count++;
  endtask

  // Drop start and hold until every result is in and the block is free.
  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  // Write a size register with the block idle, then wait out the sweep that
  // clears cells outside the new area.
  task automatic write_size(logic [CFG_IDX_W-1:0] idx, int val);
    int eff;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    eff = (val > GRID_MAX) ? GRID_MAX : val;
    if (idx == REG_WIDTH) area_w = eff;
    else area_h = eff;
    while (busy) @(negedge clk);
  endtask

  // Mostly small areas so patterns live long enough to matter; now and then
  // an empty or degenerate area, the full store, or a value that saturates.
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(0, 2);
    if (r < 10) return GRID_MAX;
    if (r < 14) return $urandom_range(GRID_MAX + 1, (1 << CFG_W) - 1);
    if (r < 20) return $urandom_range(11, GRID_MAX - 1);
    return $urandom_range(3, 10);
  endfunction

  // One run of random content: seed some live cells, step a few generations
  // and probe the result. A few episodes are plain noise instead.
  task automatic episode();
    int seeds;
    int gens;
    int probes;
    int r;
    r = $urandom_range(99);
    if (r < 10 || area_w == 0 || area_h == 0) begin
      // noise: any operation, any coordinates
      repeat ($urandom_range(4, 12))
        issue(op_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
              1'($urandom_range(1)));
      return;
    end
    seeds = $urandom_range(2, (area_w * area_h < 44) ? area_w * area_h / 2 + 2 : 24);
    repeat (seeds) begin
      if ($urandom_range(99) < 8)
        issue(OP_WRITE, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      else
        issue(OP_WRITE, $urandom_range(area_w - 1), $urandom_range(area_h - 1),
              $urandom_range(99) < 80);
    end
    gens = $urandom_range(1, 3);
    repeat (gens) begin
      issue(OP_ADVANCE, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      probes = $urandom_range(3, 8);
      repeat (probes) begin
        if ($urandom_range(99) < 15)
          issue(OP_READ, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
        else
          issue(OP_READ, $urandom_range(area_w - 1), $urandom_range(area_h - 1),
                1'($urandom_range(1)));
      end
    end
    if ($urandom_range(99) < 12) begin
      issue(OP_CLEAR, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      issue(OP_READ, $urandom_range(area_w - 1), $urandom_range(area_h - 1),
            1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(int pct, int quota);
    int target;
    idle_pct = pct;
    target   = stim_count + quota;
    while (stim_count < target) begin
      // resize one side only now and then, so old content meets the sweep
      if ($urandom_range(99) < 30)
        write_size($urandom_range(1) ? REG_WIDTH : REG_HEIGHT, pick_size());
      else begin
        write_size(REG_WIDTH, pick_size());
        write_size(REG_HEIGHT, pick_size());
      end
      repeat ($urandom_range(1, 4)) episode();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_op         = OP_WRITE;
    in_cell_x     = '0;
    in_cell_y     = '0;
    in_cell_value = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_data      = '0;
    area_w        = GRID_RESET_SIZE;
    area_h        = GRID_RESET_SIZE;
    stim_count    = 0;
    idle_pct      = 36;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Far corner on the reset-sized grid: empty, then live
    issue(OP_READ, 63, 63, 1'b1);
    issue(OP_WRITE, 63, 63, 1'b1);
    issue(OP_READ, 63, 63, 1'b0);
    // A read ignores the value field
    issue(OP_WRITE, 0, 0, 1'b1);
    issue(OP_READ, 0, 0, 1'b1);
    // Lone cells die; the advance ignores its coordinate fields
    issue(OP_ADVANCE, 63, 63, 1'b1);
    issue(OP_READ, 0, 0, 1'b0);
    // Blinker: horizontal bar turns vertical
    issue(OP_WRITE, 30, 20, 1'b1);
    issue(OP_WRITE, 31, 20, 1'b1);
    issue(OP_WRITE, 32, 20, 1'b1);
    issue(OP_ADVANCE, 0, 0, 1'b0);
    issue(OP_READ, 31, 19, 1'b0);
    issue(OP_READ, 31, 21, 1'b0);
    issue(OP_READ, 30, 20, 1'b0);
    // Shrink then regrow past the maximum: the corner comes back dead
    issue(OP_WRITE, 63, 63, 1'b1);
    write_size(REG_WIDTH, 10);
    write_size(REG_WIDTH, (1 << CFG_W) - 1);
    issue(OP_READ, 63, 63, 1'b1);
    // Clear wipes the grid whatever its fields say
    issue(OP_WRITE, 5, 5, 1'b1);
    issue(OP_CLEAR, 63, 63, 1'b1);
    issue(OP_READ, 5, 5, 1'b0);
    // Zero height: no area at all, writes dropped and reads give 0
    write_size(REG_HEIGHT, 0);
    issue(OP_WRITE, 5, 5, 1'b1);
    issue(OP_READ, 5, 5, 1'b1);
    issue(OP_ADVANCE, 5, 5, 1'b0);
    write_size(REG_HEIGHT, GRID_MAX);
    issue(OP_READ, 5, 5, 1'b0);

    run_phase(36, 620);
    run_phase(83, 620);
    run_phase(0, 610);

    // Let the last results land, then give the block time to misbehave
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- life_automaton_grid.f -----
hw/rtl/lag_pkg.sv
hw/rtl/lag_datapath.sv
hw/rtl/lag_ctrl.sv
hw/rtl/life_automaton_grid.sv
dv/life_automaton_grid_checker.sv
dv/tb_life_automaton_grid.sv
